// ===== hdl/lznhc_pkg.sv =====
// Shared constants and types for the nibble history copy unit.
package lznhc_pkg;

   localparam int HIST_AW   = 16;
   localparam int HIST_DEPTH = 1 << HIST_AW;
   localparam int NIB_W     = 4;
   localparam int OFF_W     = 16;
   localparam int LEN_W     = 7;
   localparam int MAX_RUN   = 64;
   localparam int QUEUE_AW  = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   localparam logic ACT_LITERAL = 1'b0;
   localparam logic ACT_MATCH   = 1'b1;

   typedef struct packed {
      logic             is_lit;
      logic [NIB_W-1:0] nib;
      logic [OFF_W-1:0] offset;
      logic [LEN_W-1:0] len;
   } cmd_type;

endpackage

// ===== hdl/lznhc_cmd_queue.sv =====
// Short command queue between the front and back parts.
module lznhc_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lznhc_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output lznhc_pkg::cmd_type head,
   output logic               empty
);

   lznhc_pkg::cmd_type entry_ff [lznhc_pkg::QUEUE_DEPTH];
   logic [lznhc_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lznhc_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lznhc_pkg::QUEUE_AW:0]   count_ff, count_in;

   always_comb begin
      full      = (count_ff == (lznhc_pkg::QUEUE_AW+1)'(lznhc_pkg::QUEUE_DEPTH));
      empty     = (count_ff == '0);
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff + lznhc_pkg::QUEUE_AW'(push);
      rd_ptr_in = rd_ptr_ff + lznhc_pkg::QUEUE_AW'(pop);
      count_in  = count_ff + (lznhc_pkg::QUEUE_AW+1)'(push)
                  - (lznhc_pkg::QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/lznhc_front.sv =====
// Front part: accepts requests, saturates lengths and drops empty matches.
module lznhc_front (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lznhc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 q_full,
   output logic                                 q_push,
   output lznhc_pkg::cmd_type                   q_cmd
);

   logic [lznhc_pkg::LEN_W-1:0] raw_len;
   logic                        is_lit;
   logic                        drop;

   always_comb begin
      is_lit  = (req_tuser == lznhc_pkg::ACT_LITERAL);
      raw_len = req_tdata[26:20];
      drop    = !is_lit && (raw_len == '0);

      q_cmd.is_lit = is_lit;
      q_cmd.nib    = req_tdata[3:0];
      q_cmd.offset = req_tdata[19:4];
      q_cmd.len    = (raw_len > lznhc_pkg::LEN_W'(lznhc_pkg::MAX_RUN))
                     ? lznhc_pkg::LEN_W'(lznhc_pkg::MAX_RUN) : raw_len;

      req_tready = !q_full;
      q_push     = req_tvalid && !q_full && !drop;
   end

endmodule

// ===== hdl/lznhc_back.sv =====
// Back part: issues history reads, writes copied nibbles and drives results.
module lznhc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  lznhc_pkg::cmd_type               head,
   input  logic                             q_empty,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lznhc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast
);

   logic [lznhc_pkg::NIB_W-1:0] hist_mem [lznhc_pkg::HIST_DEPTH];

   logic [lznhc_pkg::LEN_W-1:0]   run_rem_ff, run_rem_in;
   logic [lznhc_pkg::OFF_W-1:0]   run_off_ff;
   logic [lznhc_pkg::HIST_AW-1:0] issue_wp_ff, issue_wp_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_lit_ff;
   logic [lznhc_pkg::NIB_W-1:0]   s1_nib_ff;
   logic                          s1_last_ff;
   logic [lznhc_pkg::HIST_AW-1:0] s1_dst_ff;

   logic [lznhc_pkg::NIB_W-1:0]   rd_data_ff;
   logic                          byp_ff;
   logic [lznhc_pkg::NIB_W-1:0]   byp_data_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lznhc_pkg::NIB_W-1:0]   rsp_nib_ff;
   logic                          rsp_last_ff;

   logic                          out_free, fire1, adv, from_run, issue;
   logic                          iss_lit, iss_last;
   logic [lznhc_pkg::OFF_W-1:0]   iss_off;
   logic [lznhc_pkg::HIST_AW-1:0] src;
   logic [lznhc_pkg::NIB_W-1:0]   wr_nib;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      fire1    = s1_valid_ff && out_free;
      adv      = !s1_valid_ff || fire1;
      from_run = (run_rem_ff != '0);
      issue    = adv && (from_run || !q_empty);
      q_pop    = adv && !from_run && !q_empty;

      iss_lit  = from_run ? 1'b0 : head.is_lit;
      iss_off  = from_run ? run_off_ff : head.offset;
      iss_last = from_run ? (run_rem_ff == lznhc_pkg::LEN_W'(1))
                          : (head.is_lit || head.len == lznhc_pkg::LEN_W'(1));
      src      = issue_wp_ff - lznhc_pkg::HIST_AW'(iss_off);

      run_rem_in = run_rem_ff;
      if (issue) begin
         if (from_run) begin
            run_rem_in = run_rem_ff - lznhc_pkg::LEN_W'(1);
         end else if (head.is_lit) begin
            run_rem_in = '0;
         end else begin
            run_rem_in = head.len - lznhc_pkg::LEN_W'(1);
         end
      end
      issue_wp_in = issue_wp_ff + lznhc_pkg::HIST_AW'(issue);

      s1_valid_in = issue ? 1'b1 : (fire1 ? 1'b0 : s1_valid_ff);
      wr_nib      = s1_lit_ff ? s1_nib_ff : (byp_ff ? byp_data_ff : rd_data_ff);

      rsp_valid_in = fire1 ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (fire1) begin
         hist_mem[s1_dst_ff] <= wr_nib;
      end
      if (issue) begin
         rd_data_ff  <= hist_mem[src];
         byp_ff      <= fire1 && (s1_dst_ff == src);
         byp_data_ff <= wr_nib;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         run_off_ff <= head.offset;
      end
      if (issue) begin
         s1_lit_ff  <= iss_lit;
         s1_nib_ff  <= head.nib;
         s1_last_ff <= iss_last;
         s1_dst_ff  <= issue_wp_ff;
      end
      if (fire1) begin
         rsp_nib_ff  <= wr_nib;
         rsp_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_rem_ff   <= '0;
         issue_wp_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_rem_ff   <= run_rem_in;
         issue_wp_ff  <= issue_wp_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lznhc_pkg::RSP_DATA_W - lznhc_pkg::NIB_W){1'b0}}, rsp_nib_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/lz_nibble_history_copy_unit.sv =====
// LZ decoder back end on 4-bit symbols: literal and match copy into a history window.
//
// Input channel req_*: one request is a literal (tuser 0) or a match (tuser 1).
// A literal is stored at the write position and returned as one result.
// A match copies its length of nibbles, each from offset nibbles behind the
// write position, one after another, so overlapping copies repeat a pattern.
// Lengths above 64 are clipped to 64; a match of length zero gives no result.
// Output channel rsp_*: one nibble per result, tlast on the last one of a request.
// Path: a taken request is written to the command queue, then registered in
// the issue stage, then in the result register that drives rsp_tvalid.
// Throughput: one result per cycle while the receiver is ready; a match gives
// one result per copied nibble, through the single read and write port of the
// 64K x 4 history memory. A four-entry command queue decouples the input.
// Reset clears the write position and all control; history contents are
// undefined until written, and no clearing pass runs.
// A stalled receiver holds the result register; the back end then halts and
// the queue fills before req_tready drops.
module lz_nibble_history_copy_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [3:0] literal_nibble, [19:4] match_offset, [26:20] match_length, [31:27] zero
   input  logic [lznhc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [3:0] out_nibble, [7:4] zero
   output logic [lznhc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast
);

   lznhc_pkg::cmd_type q_cmd, q_head;
   logic               q_push, q_full, q_pop, q_empty;

   lznhc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   lznhc_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   lznhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
